// File: rtl/lat_pkg.sv
// lat_pkg: shared types, sizes and status codes of the live allocation tracker
// no dependencies; imported by every module of the tracker

package lat_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BYTE_W      = 32 + $clog2(TABLE_DEPTH);

  // field widths
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned CALLS_W   = 32;
  localparam int unsigned ENTRIES_W = 11;
  localparam int unsigned BYTES_W   = 42;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_TRACKED = 3'd0,
    ST_FULL    = 3'd1,
    ST_REL_OK  = 3'd2,
    ST_REL_BAD = 3'd3,
    ST_NULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SEARCH,
    S_LAST,
    S_MOVE,
    S_DONE
  } lat_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  alloc_size;
  } in_word_t;

  typedef struct packed {
    status_e               status;
    logic [SIZE_W-1:0]     freed_size;
    logic [CALLS_W-1:0]    alloc_calls;
    logic [CALLS_W-1:0]    release_calls;
    logic [CALLS_W-1:0]    invalid_releases;
    logic [ENTRIES_W-1:0]  live_entries;
    logic [BYTES_W-1:0]    live_bytes;
    logic                  overflow_seen;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } mem_req_t;

  function automatic logic [CALLS_W-1:0] sat_inc(input logic [CALLS_W-1:0] v);
    return (v == {CALLS_W{1'b1}}) ? v : v + CALLS_W'(1);
  endfunction

endpackage

// File: rtl/lat_table.sv
// lat_table: entry memory holding address and size pairs
// one write port, one read port with registered data; uses lat_pkg

module lat_table (
  input  logic              clk_i,
  input  lat_pkg::mem_req_t mem_req_i,
  output lat_pkg::entry_t   rd_data_o
);
  import lat_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_idx] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/lat_ctrl.sv
// lat_ctrl: request sequencer, table search and swap, counters and totals
// drives lat_table through a mem_req_t; uses lat_pkg

module lat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  lat_pkg::in_word_t  req_word_i,
  output lat_pkg::mem_req_t  mem_req_o,
  input  lat_pkg::entry_t    mem_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output lat_pkg::out_word_t res_word_o
);
  import lat_pkg::*;

  localparam int unsigned CEXT_W = (COUNT_W > ENTRIES_W) ? COUNT_W : ENTRIES_W;
  localparam int unsigned BEXT_W = (BYTE_W > BYTES_W) ? BYTE_W : BYTES_W;

  lat_state_e           state_q, state_d;
  in_word_t             req_q, req_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [BYTE_W-1:0]    bytes_q, bytes_d;
  logic [CALLS_W-1:0]   alloc_cnt_q, alloc_cnt_d;
  logic [CALLS_W-1:0]   rel_cnt_q, rel_cnt_d;
  logic [CALLS_W-1:0]   inv_cnt_q, inv_cnt_d;
  logic                 full_q, full_d;
  status_e              status_q, status_d;
  logic [SIZE_W-1:0]    freed_q, freed_d;
  logic [COUNT_W-1:0]   scan_q, scan_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;

  logic                 accept;
  logic                 hit;
  logic                 scan_done;
  logic                 has_room;
  logic [COUNT_W-1:0]   count_m1;
  logic [CEXT_W-1:0]    count_ext;
  logic [BEXT_W-1:0]    bytes_ext;
  logic [BEXT_W-1:0]    bytes_max;

  assign accept    = req_valid_i && !req_stall_o;
  assign hit       = pend_q && (mem_rdata_i.address == req_q.address);
  assign scan_done = (scan_q >= count_q);
  assign has_room  = (count_q < COUNT_W'(TABLE_DEPTH));
  assign count_m1  = count_q - COUNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_word_i.req_type == REQ_ALLOC) begin
            state_d = S_ALLOC;
          end else if (req_word_i.address == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_ALLOC: state_d = S_DONE;
      S_SEARCH: begin
        if (hit) begin
          state_d = S_LAST;
        end else if (scan_done) begin
          state_d = S_DONE;
        end
      end
      S_LAST: state_d = S_MOVE;
      S_MOVE: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: handshake and memory port
  always_comb begin
    req_stall_o       = (state_q != S_IDLE);
    res_valid_o       = (state_q == S_DONE);
    mem_req_o         = '0;
    mem_req_o.wr_data = mem_rdata_i;
    unique case (state_q)
      S_ALLOC: begin
        if (has_room) begin
          mem_req_o.wr_en           = 1'b1;
          mem_req_o.wr_idx          = count_q[IDX_W-1:0];
          mem_req_o.wr_data.address = req_q.address;
          mem_req_o.wr_data.size    = req_q.alloc_size;
        end
      end
      S_SEARCH: begin
        if (!hit && !scan_done) begin
          mem_req_o.rd_en  = 1'b1;
          mem_req_o.rd_idx = scan_q[IDX_W-1:0];
        end
      end
      S_LAST: begin
        mem_req_o.rd_en  = 1'b1;
        mem_req_o.rd_idx = count_m1[IDX_W-1:0];
      end
      S_MOVE: begin
        // last entry moves into the freed slot
        mem_req_o.wr_en  = 1'b1;
        mem_req_o.wr_idx = hit_idx_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    req_d       = req_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    alloc_cnt_d = alloc_cnt_q;
    rel_cnt_d   = rel_cnt_q;
    inv_cnt_d   = inv_cnt_q;
    full_d      = full_q;
    status_d    = status_q;
    freed_d     = freed_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_idx_d   = hit_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_word_i;
          freed_d = '0;
          scan_d  = '0;
          pend_d  = 1'b0;
          if (req_word_i.req_type == REQ_RELEASE) begin
            if (req_word_i.address == '0) begin
              status_d = ST_NULL;
            end else begin
              rel_cnt_d = sat_inc(rel_cnt_q);
            end
          end
        end
      end
      S_ALLOC: begin
        alloc_cnt_d = sat_inc(alloc_cnt_q);
        if (has_room) begin
          count_d  = count_q + COUNT_W'(1);
          bytes_d  = bytes_q + BYTE_W'(req_q.alloc_size);
          status_d = ST_TRACKED;
        end else begin
          full_d   = 1'b1;
          status_d = ST_FULL;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          hit_idx_d = pend_idx_q;
          freed_d   = mem_rdata_i.size;
          pend_d    = 1'b0;
        end else if (!scan_done) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
          scan_d     = scan_q + COUNT_W'(1);
        end else begin
          pend_d    = 1'b0;
          inv_cnt_d = sat_inc(inv_cnt_q);
          status_d  = ST_REL_BAD;
        end
      end
      S_MOVE: begin
        count_d  = count_m1;
        bytes_d  = bytes_q - BYTE_W'(freed_q);
        status_d = ST_REL_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bytes_q     <= '0;
      alloc_cnt_q <= '0;
      rel_cnt_q   <= '0;
      inv_cnt_q   <= '0;
      full_q      <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      alloc_cnt_q <= alloc_cnt_d;
      rel_cnt_q   <= rel_cnt_d;
      inv_cnt_q   <= inv_cnt_d;
      full_q      <= full_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    status_q   <= status_d;
    freed_q    <= freed_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
  end

  // result word, totals clamped to the field widths
  assign count_ext = CEXT_W'(count_q);
  assign bytes_ext = BEXT_W'(bytes_q);
  assign bytes_max = BEXT_W'({BYTES_W{1'b1}});

  always_comb begin
    res_word_o.status           = status_q;
    res_word_o.freed_size       = freed_q;
    res_word_o.alloc_calls      = alloc_cnt_q;
    res_word_o.release_calls    = rel_cnt_q;
    res_word_o.invalid_releases = inv_cnt_q;
    res_word_o.live_entries     = count_ext[ENTRIES_W-1:0];
    res_word_o.live_bytes       = (bytes_ext > bytes_max) ? bytes_max[BYTES_W-1:0]
                                                          : bytes_ext[BYTES_W-1:0];
    res_word_o.overflow_seen    = full_q;
  end

endmodule

// File: rtl/live_allocation_tracker_unit.sv
// live_allocation_tracker_unit: top level of the live allocation tracker
// sequence per word: an allocation goes through alloc, then done; a release scans the table
// one entry per cycle from entry 0 and, on a hit, reads the last entry and moves it into
// the freed slot before done; a missing release ends after the scan; a null release goes
// straight to done. one word in work at a time; its result then waits in the output register
// reset: counters, totals and flags clear at once; table contents need no clearing

module live_allocation_tracker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lat_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lat_pkg::out_word_t out_word_o
);
  import lat_pkg::*;

  // control to table request, table read data back
  mem_req_t  mem_req;
  entry_t    mem_rdata;

  // finished result from the sequencer
  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;

  // output register decouples the sequencer from a stalled consumer
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;
  logic      out_load;

  lat_table u_table (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (mem_rdata)
  );

  lat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_word_i  (in_word_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word)
  );

  // slot is free when empty or being emptied this cycle
  assign res_ready = !out_valid_q || !out_stall_i;
  assign out_load  = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/lat_checker.sv
// lat_checker: port-level checks of the live allocation tracker
// bound to live_allocation_tracker_unit; uses lat_pkg

module lat_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lat_pkg::out_word_t out_word_o
);
  import lat_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in work");

  // freed size only on a successful release
  a_freed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_REL_OK) |-> out_word_o.freed_size == '0)
    else $error("freed size nonzero without a successful release");

  // table never reports more entries than it holds
  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (TABLE_DEPTH < 2048) |->
      out_word_o.live_entries <= ENTRIES_W'(TABLE_DEPTH))
    else $error("live entries above table depth");

  // overflow flag is sticky across words
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.overflow_seen |=>
      !out_valid_o || out_word_o.overflow_seen)
    else $error("overflow flag cleared");

endmodule

bind live_allocation_tracker_unit lat_checker u_lat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// File: dv/live_allocation_tracker_unit_tb.sv
// live_allocation_tracker_unit_tb: self-checking bench for the live allocation tracker
// drives allocate/release words, predicts every result word and compares it field by field
// depends on rtl/lat_pkg.sv and rtl/live_allocation_tracker_unit.sv
`timescale 1ns / 100ps

module live_allocation_tracker_unit_tb;
  import lat_pkg::*;

  // run sizing
  localparam int unsigned RAND_WORDS  = 520;        // random words with a small table
  localparam int unsigned TAIL_WORDS  = 40;         // mixed words with no cap on the table
  localparam int unsigned DRAIN_WAIT  = 1100;       // one full-table miss plus margin
  localparam int unsigned MAX_REPORTS = 10;

  // clock, reset and the two channels
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // calm: no idling on either side while set
  logic calm = 1'b0;

  always #5 clk = ~clk;

  live_allocation_tracker_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // ---------------------------------------------------------------------------
  // allocation table mirror: same contents, counters and flag as the block
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  live_addr [TABLE_DEPTH];
  logic [SIZE_W-1:0]  live_size [TABLE_DEPTH];
  int unsigned        n_live      = 0;
  int unsigned        peak_live   = 0;
  logic [63:0]        live_total  = '0;     // kept wide, clamped when reported
  logic [CALLS_W-1:0] n_alloc     = '0;
  logic [CALLS_W-1:0] n_release   = '0;
  logic [CALLS_W-1:0] n_invalid   = '0;
  logic               full_seen   = 1'b0;

  // result words still owed by the block, oldest first
  out_word_t pending_results [$];

  // bookkeeping for the summary
  int unsigned n_words    = 0;
  int unsigned n_results  = 0;
  int unsigned n_mismatch = 0;
  int unsigned status_hits [8];

  // applies one accepted word to the mirror and returns the result it must produce
  function automatic out_word_t track_word(input in_word_t w);
    out_word_t r;
    int        hit;
    r   = '0;
    hit = -1;
    if (w.req_type == REQ_ALLOC) begin
      if (n_alloc != '1) n_alloc++;
      if (n_live < TABLE_DEPTH) begin
        live_addr[n_live] = w.address;
        live_size[n_live] = w.alloc_size;
        n_live++;
        live_total += w.alloc_size;
        r.status = ST_TRACKED;
      end else begin
        full_seen = 1'b1;
        r.status  = ST_FULL;
      end
    end else if (w.address == '0) begin
      // null release leaves everything alone
      r.status = ST_NULL;
    end else begin
      if (n_release != '1) n_release++;
      // lowest index wins when the same address is tracked twice
      for (int i = 0; i < n_live; i++) begin
        if (live_addr[i] == w.address) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        r.freed_size = live_size[hit];
        live_total  -= live_size[hit];
        // last entry moves into the freed slot
        live_addr[hit] = live_addr[n_live-1];
        live_size[hit] = live_size[n_live-1];
        n_live--;
        r.status = ST_REL_OK;
      end else begin
        if (n_invalid != '1) n_invalid++;
        r.status = ST_REL_BAD;
      end
    end
    if (n_live > peak_live) peak_live = n_live;
    r.alloc_calls      = n_alloc;
    r.release_calls    = n_release;
    r.invalid_releases = n_invalid;
    r.live_entries     = ENTRIES_W'(n_live);
    r.live_bytes       = (live_total > 64'(42'h3FF_FFFF_FFFF)) ? '1 : live_total[BYTES_W-1:0];
    r.overflow_seen    = full_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one word per call, optional idle gap before it
  // ---------------------------------------------------------------------------
  // known: the row carries a hand-written result, used instead of the mirror's
  task automatic send_word(input in_word_t w, input bit known, input out_word_t fixed);
    int unsigned gap;
    out_word_t   predicted;
    gap = (!calm && $urandom_range(0, 99) < 12) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // accepted at the first edge that sees stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = track_word(w);
    pending_results.push_back(known ? fixed : predicted);
    n_words++;
  endtask

  // random address: mostly wide random, some from a small pool to force duplicates, some zero
  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return 64'h0000_7f00_0000_1000 + 64'($urandom_range(0, 15)) * 64'd16;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  // next random word; allocations only while the table is below cap, releases
  // mostly of addresses that are live so the search actually hits
  function automatic in_word_t pick_word(input int unsigned cap);
    in_word_t w;
    int unsigned roll;
    w.address    = rand_addr();
    w.alloc_size = rand_size();
    if (n_live < cap && $urandom_range(0, 99) < 55) begin
      w.req_type = REQ_ALLOC;
    end else begin
      w.req_type = REQ_RELEASE;
      roll = $urandom_range(0, 99);
      if (roll < 65 && n_live > 0) w.address = live_addr[$urandom_range(0, n_live - 1)];
      else if (roll < 75)          w.address = '0;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  word;
    bit        known;
    out_word_t result;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t step_row(input req_type_e kind, input logic [ADDR_W-1:0] a,
                                         input logic [SIZE_W-1:0] s);
    plan_row_t p;
    p.word   = '{req_type: kind, address: a, alloc_size: s};
    p.known  = 1'b0;
    p.result = '0;
    return p;
  endfunction

  function automatic plan_row_t fixed_row(input req_type_e kind, input logic [ADDR_W-1:0] a,
                                          input logic [SIZE_W-1:0] s, input status_e st,
                                          input logic [SIZE_W-1:0] freed,
                                          input logic [CALLS_W-1:0] na,
                                          input logic [CALLS_W-1:0] nr,
                                          input logic [CALLS_W-1:0] ni,
                                          input logic [ENTRIES_W-1:0] ne,
                                          input logic [BYTES_W-1:0] nb, input logic ov);
    plan_row_t p;
    p        = step_row(kind, a, s);
    p.known  = 1'b1;
    p.result = '{status: st, freed_size: freed, alloc_calls: na, release_calls: nr,
                 invalid_releases: ni, live_entries: ne, live_bytes: nb, overflow_seen: ov};
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall, compare each accepted result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 n_results, what, want, got);
    end
  endtask

  out_word_t want_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: %p", n_results, out_word);
      end else begin
        want_word = pending_results.pop_front();
        status_hits[want_word.status]++;
        check_field("status",           out_word.status,           want_word.status);
        check_field("freed_size",       out_word.freed_size,       want_word.freed_size);
        check_field("alloc_calls",      out_word.alloc_calls,      want_word.alloc_calls);
        check_field("release_calls",    out_word.release_calls,    want_word.release_calls);
        check_field("invalid_releases", out_word.invalid_releases, want_word.invalid_releases);
        check_field("live_entries",     out_word.live_entries,     want_word.live_entries);
        check_field("live_bytes",       out_word.live_bytes,       want_word.live_bytes);
        check_field("overflow_seen",    out_word.overflow_seen,    want_word.overflow_seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t    w;
    int unsigned cap;

    // release with nothing tracked, then a null release whose size is ignored
    plan.push_back(fixed_row(REQ_RELEASE, 64'h5, 32'h0, ST_REL_BAD, 0, 0, 1, 1, 0, 0, 1'b0));
    plan.push_back(fixed_row(REQ_RELEASE, 64'h0, '1, ST_NULL, 0, 0, 1, 1, 0, 0, 1'b0));
    // allocation of address zero is tracked like any other
    plan.push_back(fixed_row(REQ_ALLOC, 64'h0, 32'h0, ST_TRACKED, 0, 1, 1, 1, 1, 0, 1'b0));
    plan.push_back(fixed_row(REQ_ALLOC, '1, '1, ST_TRACKED, 0, 2, 1, 1, 2,
                             42'hFFFF_FFFF, 1'b0));
    // duplicate addresses: releases must take the lowest slot first
    plan.push_back(step_row(REQ_ALLOC, 64'h1234, 32'd100));
    plan.push_back(step_row(REQ_ALLOC, 64'h1234, 32'd200));
    plan.push_back(step_row(REQ_ALLOC, 64'h8000_0000_0000_0000, 32'h8000_0000));
    plan.push_back(step_row(REQ_RELEASE, 64'h1234, 32'h0));
    plan.push_back(step_row(REQ_RELEASE, 64'h1234, 32'hDEAD_BEEF));
    plan.push_back(step_row(REQ_RELEASE, 64'h1234, 32'h0));
    // null release even though address zero is tracked
    plan.push_back(step_row(REQ_RELEASE, 64'h0, 32'h0));
    plan.push_back(step_row(REQ_RELEASE, '1, 32'h0));
    plan.push_back(step_row(REQ_ALLOC, 64'h5555_5555_5555_5555, 32'h5555_5555));
    plan.push_back(step_row(REQ_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA));
    plan.push_back(step_row(REQ_RELEASE, 64'hAAAA_AAAA_AAAA_AAAB, 32'h0));
    plan.push_back(step_row(REQ_RELEASE, 64'h8000_0000_0000_0000, 32'h0));
    plan.push_back(step_row(REQ_RELEASE, 64'h5555_5555_5555_5555, '1));
    plan.push_back(step_row(REQ_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0));
    plan.push_back(step_row(REQ_ALLOC, 64'h0, '1));
    plan.push_back(step_row(REQ_RELEASE, 64'h0000_0001_0000_0000, 32'h0));

    // reset held low at the start, then released at an edge
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) send_word(plan[k].word, plan[k].known, plan[k].result);

    // random words, table kept small so searches stay short; cap swings between
    // a nearly empty and a moderately full table, one stretch runs without idling
    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      calm = (n >= 150 && n < 250);
      cap  = ((n / 100) % 2 == 0) ? 8 : 48;
      w = pick_word(cap);
      send_word(w, 1'b0, '0);
    end
    calm = 1'b0;

    // mixed words with the cap lifted, table allowed to grow
    for (int unsigned n = 0; n < TAIL_WORDS; n++) begin
      w = pick_word(TABLE_DEPTH + 1);
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // let the last results drain, then leave room for any stray word
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d words sent, %0d results: %0d tracked, %0d full, %0d freed, %0d missed, %0d null",
             n_words, n_results, status_hits[ST_TRACKED], status_hits[ST_FULL],
             status_hits[ST_REL_OK], status_hits[ST_REL_BAD], status_hits[ST_NULL]);
    $display("table peaked at %0d of %0d entries, %0d field mismatches",
             peak_live, TABLE_DEPTH, n_mismatch);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
